FILE: rtl/vots_pkg.sv
package vots_pkg;

  localparam int unsigned QueueDepth = 32;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  localparam logic [7:0] IdleId        = 8'd0;
  localparam logic [7:0] SliceBaseRst  = 8'd4;
  localparam logic [9:0] SliceValueRst = 10'd4;

  // configuration register indexes
  localparam logic CfgSliceBase = 1'b0;
  localparam logic CfgIdleRt    = 1'b1;

  // item kinds
  localparam logic ModeInsert   = 1'b0;
  localparam logic ModeSchedule = 1'b1;

  // input word: mode, task_id, task_run_time, task_priority, current_runnable
  typedef struct packed {
    logic        current_runnable;
    logic [2:0]  task_priority;
    logic [31:0] task_run_time;
    logic [7:0]  task_id;
    logic        mode;
  } in_word_t;

  // output word: running_task, switched, slice_ticks, ready_count, overflow
  typedef struct packed {
    logic       overflow;
    logic [5:0] ready_count;
    logic [9:0] slice_ticks;
    logic       switched;
    logic [7:0] running_task;
  } out_word_t;

  typedef enum logic [3:0] {
    StIdle,
    StPopRd,
    StPopMv,
    StDecide,
    StInsRd,
    StInsCmp,
    StInsMv,
    StInsWr,
    StDiv,
    StOut
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic pop_start;
    logic pop_rd;
    logic pop_mv;
    logic decide;
    logic ins_start;
    logic ins_rd;
    logic ins_step;
    logic ins_wr;
    logic div_start;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_sched;
    logic queue_empty;
    logic pop_done;
    logic need_ins;
    logic ins_skip;
    logic ins_full;
    logic ins_found;
    logic mv_done;
    logic div_done;
  } dp_sts_t;

endpackage

FILE: rtl/vots_ctrl.sv
module vots_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              out_busy_i,
  input  vots_pkg::dp_sts_t sts_i,
  output vots_pkg::dp_cmd_t cmd_o,
  output logic              idle_o
);
  import vots_pkg::*;

  state_e state_q, state_d;
  // set while the insert belongs to a schedule item
  logic sched_q, sched_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sched_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sched_q <= sched_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    sched_d = sched_q;
    case (state_q)
      StIdle: begin
        if (in_fire_i) state_d = StPopRd;
      end
      StPopRd: begin
        // item decoded; pick the flow
        if (!sts_i.is_sched) begin
          sched_d = 1'b0;
          state_d = StInsRd;
        end else begin
          sched_d = 1'b1;
          state_d = sts_i.queue_empty ? StDecide : StPopMv;
        end
      end
      StPopMv: begin
        if (sts_i.pop_done) state_d = StDecide;
      end
      StDecide: begin
        state_d = sts_i.need_ins ? StInsRd : StDiv;
      end
      StInsRd: begin
        if (sts_i.ins_skip || sts_i.ins_full) state_d = sched_q ? StDiv : StOut;
        else state_d = StInsCmp;
      end
      StInsCmp: begin
        if (sts_i.ins_found) state_d = StInsMv;
      end
      StInsMv: begin
        if (sts_i.mv_done) state_d = StInsWr;
      end
      StInsWr: begin
        state_d = sched_q ? StDiv : StOut;
      end
      StDiv: begin
        if (sts_i.div_done) state_d = StOut;
      end
      StOut: begin
        if (!out_busy_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // command decode
  always_comb begin
    cmd_o = '0;
    idle_o = 1'b0;
    case (state_q)
      StIdle:   begin
        idle_o = 1'b1;
        cmd_o.load_item = in_fire_i;
      end
      StPopRd:  begin
        cmd_o.pop_start = sts_i.is_sched;
        cmd_o.ins_start = !sts_i.is_sched;
      end
      StPopMv:  cmd_o.pop_mv = 1'b1;
      StDecide: begin
        cmd_o.decide = 1'b1;
        cmd_o.ins_start = sts_i.need_ins;
        cmd_o.div_start = !sts_i.need_ins;
      end
      StInsRd:  begin
        cmd_o.ins_rd = 1'b1;
        cmd_o.div_start = (sts_i.ins_skip || sts_i.ins_full) && sched_q;
      end
      StInsCmp: cmd_o.ins_step = 1'b1;
      StInsMv:  cmd_o.pop_rd = 1'b1;
      StInsWr:  begin
        cmd_o.ins_wr = 1'b1;
        cmd_o.div_start = sched_q;
      end
      StDiv:    cmd_o.div_step = 1'b1;
      StOut:    cmd_o.out_load = !out_busy_i;
      default:  cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/vots_dp.sv
module vots_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vots_pkg::in_word_t  item_i,
  input  logic [7:0]          slice_base_i,
  input  logic [31:0]         idle_rt_i,
  input  vots_pkg::dp_cmd_t   cmd_i,
  output vots_pkg::dp_sts_t   sts_o,
  output vots_pkg::out_word_t res_o
);
  import vots_pkg::*;

  // queue storage, one row per entry
  logic [7:0]  ids_q   [QueueDepth];
  logic [31:0] keys_q  [QueueDepth];
  logic [2:0]  prios_q [QueueDepth];

  logic [CntW-1:0] len_q, len_d;
  logic [7:0]  cur_task_q;
  logic [2:0]  cur_prio_q;
  logic [9:0]  slice_q;
  in_word_t    item_q;

  // head popped by a schedule item
  logic [7:0]  head_id_q;
  logic [31:0] head_key_q;
  logic [2:0]  head_prio_q;
  logic        switched_q;

  // entry to be placed and scan/shift pointer
  logic [7:0]  ins_id_q;
  logic [31:0] ins_key_q;
  logic [2:0]  ins_prio_q;
  logic [CntW-1:0] ptr_q;
  logic [CntW-1:0] ins_ptr_q;
  logic            ovf_q;

  // restoring divider
  logic [7:0]      quo_q;
  logic [CntW:0]   rem_q;
  logic [CntW:0]   dvs_q;
  logic [3:0]      dcnt_q;

  logic [CntW:0]   rem_sh;
  logic            sched_hit;
  logic [IdxW-1:0] ptr_idx;
  logic [IdxW-1:0] ptr_prev;
  logic [9:0]      slice_d;
  logic [9:0]      quo_x3;

  assign ptr_idx  = ptr_q[IdxW-1:0];
  assign ptr_prev = IdxW'(ptr_q - 1'b1);
  assign len_d    = len_q;
  assign rem_sh   = {rem_q[CntW-1:0], quo_q[7]};
  assign sched_hit = (item_q.task_run_time >= head_key_q) || !item_q.current_runnable;
  assign quo_x3   = {2'b00, quo_q} + {1'b0, quo_q, 1'b0};
  assign slice_d  = (cur_prio_q >= 3'd2) ? quo_x3 : {2'b00, quo_q};

  // status
  always_comb begin
    sts_o = '0;
    sts_o.is_sched    = item_q.mode == ModeSchedule;
    sts_o.queue_empty = len_q == '0;
    sts_o.pop_done    = ptr_q >= len_q;
    sts_o.need_ins    = sched_hit ? item_q.current_runnable && (cur_task_q != IdleId)
                                  : head_id_q != IdleId;
    sts_o.ins_skip    = ins_id_q == IdleId;
    sts_o.ins_full    = len_q >= CntW'(QueueDepth);
    sts_o.ins_found   = (ptr_q >= len_q) || (keys_q[ptr_idx] > ins_key_q);
    sts_o.mv_done     = ptr_q <= ins_ptr_q;
    sts_o.div_done    = dcnt_q == 4'd0;
  end

  // control and payload state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      cur_task_q <= IdleId;
      cur_prio_q <= 3'd0;
      slice_q    <= SliceValueRst;
      ptr_q      <= '0;
      ins_ptr_q  <= '0;
      dcnt_q     <= '0;
      ovf_q      <= 1'b0;
      switched_q <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        ovf_q      <= 1'b0;
        switched_q <= 1'b0;
      end
      // pop: latch head, then shift down
      if (cmd_i.pop_start) begin
        head_id_q   <= ids_q[0];
        head_key_q  <= keys_q[0];
        head_prio_q <= prios_q[0];
        ptr_q       <= CntW'(1);
      end
      if (cmd_i.pop_start && len_q == '0) begin
        head_id_q   <= IdleId;
        head_key_q  <= idle_rt_i;
        head_prio_q <= 3'd0;
      end
      if (cmd_i.pop_mv) begin
        if (ptr_q >= len_q) len_q <= len_q - 1'b1;
        else ptr_q <= ptr_q + 1'b1;
      end
      // decision
      if (cmd_i.decide) begin
        if (sched_hit) begin
          ins_id_q    <= item_q.current_runnable ? cur_task_q : IdleId;
          ins_key_q   <= item_q.task_run_time;
          ins_prio_q  <= item_q.task_priority;
          cur_task_q  <= head_id_q;
          cur_prio_q  <= head_prio_q;
          switched_q  <= 1'b1;
        end else begin
          ins_id_q    <= head_id_q;
          ins_key_q   <= head_key_q;
          ins_prio_q  <= head_prio_q;
          cur_prio_q  <= item_q.task_priority;
        end
      end
      if (cmd_i.ins_start && !cmd_i.decide) begin
        ins_id_q   <= item_q.task_id;
        ins_key_q  <= item_q.task_run_time;
        ins_prio_q <= item_q.task_priority;
      end
      // insert: scan for slot
      if (cmd_i.ins_rd) begin
        ptr_q <= '0;
        if (ins_id_q != IdleId && len_q >= CntW'(QueueDepth) && item_q.mode == ModeInsert)
          ovf_q <= 1'b1;
      end
      if (cmd_i.ins_step) begin
        if (sts_o.ins_found) begin
          ins_ptr_q <= ptr_q;
          ptr_q     <= len_q;
        end else begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
      if (cmd_i.pop_rd && ptr_q > ins_ptr_q) ptr_q <= ptr_q - 1'b1;
      if (cmd_i.ins_wr) len_q <= len_q + 1'b1;
      // slice division
      if (cmd_i.div_start) begin
        dcnt_q <= 4'd8;
      end
      if (cmd_i.div_step && dcnt_q != 4'd0) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.div_step && dcnt_q == 4'd0) slice_q <= slice_d;
    end
  end

  // divider datapath, quotient shifts in where the dividend shifts out
  // divisor counts the entry written in the same cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= item_i;
    if (cmd_i.div_start) begin
      quo_q <= slice_base_i;
      rem_q <= '0;
      dvs_q <= (CntW+1)'(len_q) + (cmd_i.ins_wr ? (CntW+1)'(2) : (CntW+1)'(1));
    end else if (cmd_i.div_step && dcnt_q != 4'd0) begin
      if (rem_sh >= dvs_q) begin
        rem_q <= rem_sh - dvs_q;
        quo_q <= {quo_q[6:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[6:0], 1'b0};
      end
    end
  end

  // queue memory: one move or one write per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_mv && ptr_q < len_q) begin
      ids_q[ptr_prev]   <= ids_q[ptr_idx];
      keys_q[ptr_prev]  <= keys_q[ptr_idx];
      prios_q[ptr_prev] <= prios_q[ptr_idx];
    end
    if (cmd_i.pop_rd && ptr_q > ins_ptr_q) begin
      ids_q[ptr_idx]   <= ids_q[ptr_prev];
      keys_q[ptr_idx]  <= keys_q[ptr_prev];
      prios_q[ptr_idx] <= prios_q[ptr_prev];
    end
    if (cmd_i.ins_wr) begin
      ids_q[ins_ptr_q[IdxW-1:0]]   <= ins_id_q;
      keys_q[ins_ptr_q[IdxW-1:0]]  <= ins_key_q;
      prios_q[ins_ptr_q[IdxW-1:0]] <= ins_prio_q;
    end
  end

  // result word
  always_comb begin
    res_o.running_task = cur_task_q;
    res_o.switched     = switched_q;
    res_o.slice_ticks  = slice_q;
    res_o.ready_count  = 6'(len_d);
    res_o.overflow     = ovf_q;
  end

endmodule

FILE: rtl/vruntime_ordered_task_scheduler_unit.sv
// an insert scans the sorted queue for its slot and shifts the tail up; a schedule item
// shifts the queue down, then does the sorted requeue scan and shift and an 8 step slice divider
// one item at a time: a new item is taken only once the last result is in the output register
// the output register holds a word while the next item is taken in
// reset: queue empty, idle task running, slice 4, slice_base 4, idle run time 0
module vruntime_ordered_task_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode, task_id, task_run_time, task_priority, current_runnable; 3 pad bits
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // running_task, switched, slice_ticks, ready_count, overflow; 6 pad bits
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import vots_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  out_word_t res;
  logic      idle;
  logic      in_fire;
  logic      out_vld_q;
  out_word_t out_q;
  logic [7:0]  slice_base_q;
  logic [31:0] idle_rt_q;

  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && idle;
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_base_q <= SliceBaseRst;
      idle_rt_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSliceBase: slice_base_q <= cfg_data_i[7:0];
        CfgIdleRt:    idle_rt_q    <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  vots_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_fire_i  (in_fire),
    .out_busy_i (out_vld_q && !m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  vots_dp u_dp (
    .clk_i,
    .rst_ni,
    .item_i       (in_word_t'(s_axis_tdata[44:0])),
    .slice_base_i (slice_base_q),
    .idle_rt_i    (idle_rt_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_o        (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) out_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_q};

endmodule

FILE: rtl/vots_checker.sv
module vots_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // an accepted item blocks the input next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // ready count never exceeds the depth
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[24:19] <= 6'd32)
    else $error("ready count out of range");

  // overflow only on inserts, which never switch
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[25] && m_axis_tdata[8]))
    else $error("overflow with switch");

endmodule

bind vruntime_ordered_task_scheduler_unit vots_checker u_vots_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

FILE: tb/sv/vruntime_ordered_task_scheduler_unit_tb.sv
`timescale 1ns / 100ps

module vruntime_ordered_task_scheduler_unit_tb;
  import vots_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;

  // software copy of the ready queue and scheduler state
  class sched_scoreboard;
    logic [7:0]  ids[$];
    logic [31:0] keys[$];
    logic [2:0]  prios[$];
    logic [7:0]  cur_task;
    logic [2:0]  cur_prio;
    logic [9:0]  slice_val;
    logic [7:0]  slice_base;
    logic [31:0] idle_rt;
    out_word_t   expected_words[$];
    int unsigned errors;
    int unsigned checked;

    function void reset_state();
      ids.delete();
      keys.delete();
      prios.delete();
      cur_task   = IdleId;
      cur_prio   = '0;
      slice_val  = SliceValueRst;
      slice_base = SliceBaseRst;
      idle_rt    = '0;
      expected_words.delete();
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == CfgSliceBase) begin
        slice_base = val[7:0];
      end else begin
        idle_rt = val;
      end
    endfunction

    // sorted insert behind equal keys; returns 0 when full
    function bit queue_task(logic [7:0] id, logic [31:0] key, logic [2:0] pr);
      int pos;
      if (id == IdleId) return 1;
      if (ids.size() >= QueueDepth) return 0;
      pos = 0;
      while (pos < ids.size() && keys[pos] <= key) pos++;
      ids.insert(pos, id);
      keys.insert(pos, key);
      prios.insert(pos, pr);
      return 1;
    endfunction

    function void note_item(in_word_t w);
      out_word_t   o;
      logic [7:0]  hid;
      logic [31:0] hkey;
      logic [2:0]  hpr;
      int unsigned sl;
      o = '0;
      if (w.mode == ModeInsert) begin
        o.overflow = !queue_task(w.task_id, w.task_run_time, w.task_priority);
      end else begin
        if (ids.size() == 0) begin
          hid = IdleId;
          hkey = idle_rt;
          hpr = '0;
        end else begin
          hid = ids.pop_front();
          hkey = keys.pop_front();
          hpr = prios.pop_front();
        end
        if (w.task_run_time >= hkey || !w.current_runnable) begin
          if (w.current_runnable) void'(queue_task(cur_task, w.task_run_time, w.task_priority));
          cur_task = hid;
          cur_prio = hpr;
          o.switched = 1'b1;
        end else begin
          void'(queue_task(hid, hkey, hpr));
          cur_prio = w.task_priority;
        end
        sl = slice_base / (ids.size() + 1);
        if (cur_prio >= 2) sl = sl * 3;
        slice_val = sl[9:0];
      end
      o.running_task = cur_task;
      o.slice_ticks  = slice_val;
      o.ready_count  = 6'(ids.size());
      expected_words.push_back(o);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned exp);
      errors++;
      $display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, exp);
    endtask

    task check_word(out_word_t got);
      out_word_t exp;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 32'(got), 0);
        return;
      end
      exp = expected_words.pop_front();
      if (got.running_task != exp.running_task)
        report_mismatch("running_task", 32'(got.running_task), 32'(exp.running_task));
      if (got.switched != exp.switched)
        report_mismatch("switched", 32'(got.switched), 32'(exp.switched));
      if (got.slice_ticks != exp.slice_ticks)
        report_mismatch("slice_ticks", 32'(got.slice_ticks), 32'(exp.slice_ticks));
      if (got.ready_count != exp.ready_count)
        report_mismatch("ready_count", 32'(got.ready_count), 32'(exp.ready_count));
      if (got.overflow != exp.overflow)
        report_mismatch("overflow", 32'(got.overflow), 32'(exp.overflow));
      checked++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;

  sched_scoreboard sb;
  int unsigned cycle_cnt;
  int unsigned sent_cnt;
  int unsigned sched_cnt;
  int unsigned overflow_cnt;
  bit          sink_idle_on;
  bit          src_idle_on;
  bit          hold_sink;

  vruntime_ordered_task_scheduler_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result checking at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata[25:0]);
  end

  // receiver ready, with random stalls and a forced long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni || hold_sink) m_axis_tready <= 1'b0;
    else if (sink_idle_on) m_axis_tready <= ($urandom_range(99) >= 19);
    else m_axis_tready <= 1'b1;
  end

  task send_item(in_word_t w);
    @(negedge clk_i);
    while (src_idle_on && $urandom_range(99) < 19) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'd0, w};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(w);
    sent_cnt++;
    if (w.mode == ModeSchedule) sched_cnt++;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task send_fields(logic md, logic [7:0] id, logic [31:0] rt, logic [2:0] pr, logic rn);
    in_word_t w;
    w.mode = md;
    w.task_id = id;
    w.task_run_time = rt;
    w.task_priority = pr;
    w.current_runnable = rn;
    send_item(w);
  endtask

  // pause until every expected word has come back, then let the block settle
  task drain();
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task write_reg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random run times mostly in a narrow band so keys collide and order matters
  function logic [31:0] rand_rt();
    case ($urandom_range(9))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2: return $urandom();
      default: return $urandom_range(40);
    endcase
  endfunction

  task random_phase(int unsigned count, int unsigned ins_pct);
    in_word_t w;
    for (int unsigned k = 0; k < count; k++) begin
      w.mode = ($urandom_range(99) < ins_pct) ? ModeInsert : ModeSchedule;
      w.task_id = ($urandom_range(19) == 0) ? IdleId : 8'($urandom_range(255));
      w.task_run_time = rand_rt();
      w.task_priority = 3'($urandom_range(7));
      w.current_runnable = ($urandom_range(3) != 0);
      send_item(w);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    cycle_cnt = 0;
    sent_cnt = 0;
    sched_cnt = 0;
    overflow_cnt = 0;
    sink_idle_on = 1'b0;
    src_idle_on = 1'b0;
    hold_sink = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgSliceBase;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset values, idle head, ties, extremes
    send_fields(ModeSchedule, 8'd0, 32'd0, 3'd0, 1'b1);
    send_fields(ModeInsert, IdleId, 32'd5, 3'd7, 1'b1);
    send_fields(ModeInsert, 8'd255, 32'hFFFF_FFFF, 3'd7, 1'b0);
    send_fields(ModeInsert, 8'd1, 32'd10, 3'd2, 1'b0);
    send_fields(ModeInsert, 8'd2, 32'd10, 3'd1, 1'b1);
    send_fields(ModeInsert, 8'd2, 32'd0, 3'd0, 1'b0);
    send_fields(ModeSchedule, 8'd0, 32'd0, 3'd3, 1'b1);
    send_fields(ModeSchedule, 8'd0, 32'd100, 3'd5, 1'b1);
    send_fields(ModeSchedule, 8'd0, 32'd1, 3'd1, 1'b0);
    send_fields(ModeSchedule, 8'd0, 32'hFFFF_FFFF, 3'd7, 1'b1);
    drain();
    write_reg(CfgSliceBase, 32'd255);
    write_reg(CfgIdleRt, 32'hFFFF_FFFF);
    send_fields(ModeSchedule, 8'hAA, 32'd7, 3'd2, 1'b1);
    send_fields(ModeSchedule, 8'h55, 32'hFFFF_FFFE, 3'd4, 1'b1);
    send_fields(ModeSchedule, 8'd0, 32'd3, 3'd0, 1'b0);
    // fill to the top and past it
    for (int k = 0; k < QueueDepth + 2; k++)
      send_fields(ModeInsert, 8'(3 + k), $urandom_range(20), 3'(k), 1'b1);
    send_fields(ModeSchedule, 8'd0, 32'd0, 3'd6, 1'b1);
    drain();

    // random part, phases with different settings
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    write_reg(CfgSliceBase, 32'd1);
    write_reg(CfgIdleRt, 32'd0);
    random_phase(300, 55);
    drain();
    write_reg(CfgSliceBase, $urandom_range(2, 254));
    write_reg(CfgIdleRt, $urandom_range(40));

    // long receiver hold-off while the sender keeps offering items
    fork
      begin
        hold_sink = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      random_phase(60, 70);
    join
    drain();

    // stretch with no idling at all, heavy inserts to hit overflow
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    write_reg(CfgSliceBase, 32'd255);
    random_phase(300, 80);
    drain();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    write_reg(CfgSliceBase, $urandom_range(1, 255));
    write_reg(CfgIdleRt, $urandom());
    random_phase(560, 50);
    drain();

    $display("sent %0d items (%0d schedules), checked %0d result words,",
             sent_cnt, sched_cnt, sb.checked);
    $display("covering ties, full queue, idle head and slice extremes");
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: vruntime_ordered_task_scheduler_unit.f
rtl/vots_pkg.sv
rtl/vots_ctrl.sv
rtl/vots_dp.sv
rtl/vruntime_ordered_task_scheduler_unit.sv
rtl/vots_checker.sv
tb/sv/vruntime_ordered_task_scheduler_unit_tb.sv
